// ===== rtl/matrix_chain_order_dp_unit_assert.svh =====
// assertion macros for the matrix chain order unit checker
// no dependencies; included by files that carry concurrent assertions
`ifndef MATRIX_CHAIN_ORDER_DP_UNIT_ASSERT_SVH
`define MATRIX_CHAIN_ORDER_DP_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MCODP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcodp assertion failed");

// next-cycle implication, disabled during reset
`define MCODP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcodp assertion failed");

`endif

// ===== rtl/mcodp_pkg.sv =====
// shared constants for the matrix chain order unit
// no dependencies
`default_nettype none

package mcodp_pkg;

    localparam int MAX_MATRICES_DEF = 8;
    localparam int DIM_WIDTH_DEF    = 12;

    localparam int COST_W   = 48;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/matrix_chain_order_dp_unit.sv =====
// matrix chain order unit: cheapest parenthesization cost and split per subchain
// depends on mcodp_pkg
//
// usage:
//   s_ channel: one dimension per beat (p0, p1, ...); s_last marks the final one.
//   beats without s_last are stored and give no result.
//   after s_last the unit fills the cost table by chain length, then by first
//   index, and sends one m_ beat per pair (row < col); the beat with
//   m_done_res high covers the whole chain. one matrix gives a single (1,1)
//   beat with zero cost; fewer than two dimensions or more than
//   MAX_MATRICES+1 give a single status beat.
//   while a chain is worked on s_ready is low. each subchain first fetches its
//   outer dimensions and forms their product on the shared multiplier, then
//   steps through each split point (table read, multiply and add, saturating
//   add and compare), then hands its result to the output register. eight
//   matrices: 28 pairs, 84 split points.
//   the output register lets the next pair compute while a result waits; a
//   stalled m_ready holds the unit at its next result, payload unchanged.
//   reset (aresetn low, synchronous) empties the stored chain and the output.
`default_nettype none

module matrix_chain_order_dp_unit #(
    parameter int MAX_MATRICES = mcodp_pkg::MAX_MATRICES_DEF,
    parameter int DIM_WIDTH    = mcodp_pkg::DIM_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [DIM_WIDTH-1:0]            s_dimension,
    input  wire logic                            s_last,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [mcodp_pkg::IDX_W-1:0]          m_row,
    output logic [mcodp_pkg::IDX_W-1:0]          m_col,
    output logic [mcodp_pkg::COST_W-1:0]         m_cost,
    output logic [mcodp_pkg::IDX_W-1:0]          m_split,
    output logic [mcodp_pkg::STATUS_W-1:0]       m_status,
    output logic                                 m_done_res
);
    import mcodp_pkg::*;

    localparam int TSIZE = MAX_MATRICES + 1;
    localparam int IW    = $clog2(TSIZE);
    localparam int CW    = $clog2(TSIZE + 1);
    localparam int MW    = $clog2(MAX_MATRICES);
    localparam int PW    = 2 * DIM_WIDTH;
    localparam int XW    = 3 * DIM_WIDTH;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PA   = 8'b0000_0010,
        S_PB   = 8'b0000_0100,
        S_PC   = 8'b0000_1000,
        S_RD   = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_CMP  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

    logic [DIM_WIDTH-1:0] dims_mem [0:TSIZE-1];
    logic [COST_W-1:0]    cost_mem [0:(1 << (2 * MW)) - 1];

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 too_long_reg, too_long_next;
    logic [IW-1:0]        i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IW-1:0]        l_reg, l_next, n_reg, n_next;
    logic [IW-1:0]        bk_reg, bk_next;
    logic [COST_W-1:0]    best_reg, best_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 single_reg, single_next;
    logic                 first_reg, first_next;
    logic                 za_reg, za_next, zb_reg, zb_next;
    logic [DIM_WIDTH-1:0] a_reg, a_next;
    logic [PW-1:0]        pij_reg, pij_next;
    logic [COST_W-1:0]    prod_reg, prod_next, sum_reg, sum_next;

    logic                 m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]     row_reg, row_next, col_reg, col_next, split_reg, split_next;
    logic [COST_W-1:0]    cost_reg, cost_next;
    logic [STATUS_W-1:0]  mstat_reg, mstat_next;
    logic                 done_reg, done_next;

    logic [DIM_WIDTH-1:0] dim_rd;
    logic [COST_W-1:0]    ca_rd, cb_rd;
    logic [IW-1:0]        dim_addr;
    logic [IW-1:0]        im1, jm1, km1;
    logic [PW-1:0]        mul_a;
    logic [XW-1:0]        mul_p;
    logic [COST_W-1:0]    ca_eff, cb_eff, q_val;
    logic                 in_beat, store_ok, long_eff, out_free, out_load, fin;
    logic [CW-1:0]        cnt_eff;

    assign s_ready    = (state_reg == S_IDLE);
    assign in_beat    = s_valid && s_ready;
    assign store_ok   = (count_reg < CW'(TSIZE));
    assign cnt_eff    = store_ok ? count_reg + CW'(1) : count_reg;
    assign long_eff   = too_long_reg || !store_ok;
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = (state_reg == S_OUT) && out_free;
    assign fin        = single_reg || (l_reg == n_reg);

    assign im1 = i_reg - IW'(1);
    assign jm1 = j_reg - IW'(1);
    assign km1 = k_reg - IW'(1);

    // the one shared multiplier: outer product first, then one term per split
    assign mul_a = (state_reg == S_PC) ? PW'(a_reg) : pij_reg;
    assign mul_p = XW'(mul_a) * XW'(dim_rd);

    assign ca_eff = za_reg ? '0 : ca_rd;
    assign cb_eff = zb_reg ? '0 : cb_rd;
    assign q_val  = sat_add(sum_reg, prod_reg);

    always_comb begin
        case (state_reg)
            S_PA:    dim_addr = im1;
            S_PB:    dim_addr = j_reg;
            default: dim_addr = k_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_beat && store_ok) begin
            dims_mem[count_reg[IW-1:0]] <= s_dimension;
        end
        dim_rd <= dims_mem[dim_addr];
    end

    always_ff @(posedge aclk) begin
        if (out_load && !single_reg) begin
            cost_mem[{im1[MW-1:0], jm1[MW-1:0]}] <= best_reg;
        end
        if (state_reg == S_RD) begin
            ca_rd <= cost_mem[{im1[MW-1:0], km1[MW-1:0]}];
            cb_rd <= cost_mem[{k_reg[MW-1:0], jm1[MW-1:0]}];
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        too_long_next = too_long_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        l_next        = l_reg;
        n_next        = n_reg;
        bk_next       = bk_reg;
        best_next     = best_reg;
        status_next   = status_reg;
        single_next   = single_reg;
        first_next    = first_reg;
        za_next       = za_reg;
        zb_next       = zb_reg;
        a_next        = a_reg;
        pij_next      = pij_reg;
        prod_next     = prod_reg;
        sum_next      = sum_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        row_next      = row_reg;
        col_next      = col_reg;
        cost_next     = cost_reg;
        split_next    = split_reg;
        mstat_next    = mstat_reg;
        done_next     = done_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    if (store_ok) begin
                        count_next = cnt_eff;
                    end else begin
                        too_long_next = 1'b1;
                    end
                    if (s_last) begin
                        count_next    = '0;
                        too_long_next = 1'b0;
                        best_next     = '0;
                        bk_next       = '0;
                        single_next   = 1'b1;
                        i_next        = '0;
                        j_next        = '0;
                        state_next    = S_OUT;
                        if (long_eff) begin
                            status_next = ST_LONG;
                        end else if (cnt_eff < CW'(2)) begin
                            status_next = ST_SHORT;
                        end else if (cnt_eff == CW'(2)) begin
                            status_next = ST_OK;
                            i_next      = IW'(1);
                            j_next      = IW'(1);
                        end else begin
                            status_next = ST_OK;
                            single_next = 1'b0;
                            n_next      = IW'(cnt_eff - CW'(1));
                            l_next      = IW'(2);
                            i_next      = IW'(1);
                            j_next      = IW'(2);
                            state_next  = S_PA;
                        end
                    end
                end
            end
            S_PA: begin
                k_next     = i_reg;
                first_next = 1'b1;
                state_next = S_PB;
            end
            S_PB: begin
                a_next     = dim_rd;
                state_next = S_PC;
            end
            S_PC: begin
                pij_next   = PW'(mul_p);
                state_next = S_RD;
            end
            S_RD: begin
                za_next    = (k_reg == i_reg);
                zb_next    = (k_reg + IW'(1) == j_reg);
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = COST_W'(mul_p);
                sum_next   = sat_add(ca_eff, cb_eff);
                state_next = S_CMP;
            end
            S_CMP: begin
                // strict compare keeps the smallest split on ties
                if (first_reg || (q_val < best_reg)) begin
                    best_next = q_val;
                    bk_next   = k_reg;
                end
                first_next = 1'b0;
                if (k_reg == jm1) begin
                    state_next = S_OUT;
                end else begin
                    k_next     = k_reg + IW'(1);
                    state_next = S_RD;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    row_next     = IDX_W'(i_reg);
                    col_next     = IDX_W'(j_reg);
                    cost_next    = best_reg;
                    split_next   = IDX_W'(bk_reg);
                    mstat_next   = status_reg;
                    done_next    = fin;
                    if (fin) begin
                        state_next = S_IDLE;
                    end else if (j_reg == n_reg) begin
                        l_next     = l_reg + IW'(1);
                        i_next     = IW'(1);
                        j_next     = l_reg + IW'(1);
                        state_next = S_PA;
                    end else begin
                        i_next     = i_reg + IW'(1);
                        j_next     = j_reg + IW'(1);
                        state_next = S_PA;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            too_long_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            too_long_reg <= too_long_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        l_reg      <= l_next;
        n_reg      <= n_next;
        bk_reg     <= bk_next;
        best_reg   <= best_next;
        status_reg <= status_next;
        single_reg <= single_next;
        first_reg  <= first_next;
        za_reg     <= za_next;
        zb_reg     <= zb_next;
        a_reg      <= a_next;
        pij_reg    <= pij_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        cost_reg   <= cost_next;
        split_reg  <= split_next;
        mstat_reg  <= mstat_next;
        done_reg   <= done_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_row      = row_reg;
    assign m_col      = col_reg;
    assign m_cost     = cost_reg;
    assign m_split    = split_reg;
    assign m_status   = mstat_reg;
    assign m_done_res = done_reg;

endmodule

`default_nettype wire

// ===== rtl/mcodp_checker.sv =====
// port-level checks for the matrix chain order unit, bound to its top level
// depends on mcodp_pkg and matrix_chain_order_dp_unit_assert.svh
`default_nettype none

`include "matrix_chain_order_dp_unit_assert.svh"

module mcodp_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              s_last,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [mcodp_pkg::IDX_W-1:0]       m_row,
    input wire logic [mcodp_pkg::IDX_W-1:0]       m_col,
    input wire logic [mcodp_pkg::COST_W-1:0]      m_cost,
    input wire logic [mcodp_pkg::IDX_W-1:0]       m_split,
    input wire logic [mcodp_pkg::STATUS_W-1:0]    m_status,
    input wire logic                              m_done_res
);
    import mcodp_pkg::*;

    // status beats carry nothing but the code and the done flag
    `MCODP_ASSERT_IMP(a_status_beat, aclk, aresetn,
        m_valid && (m_status != ST_OK),
        (m_row == '0) && (m_col == '0) && (m_cost == '0) && (m_split == '0) && m_done_res)

    // a one-matrix chain is a single free beat
    `MCODP_ASSERT_IMP(a_single_beat, aclk, aresetn,
        m_valid && (m_status == ST_OK) && (m_row == m_col),
        (m_cost == '0) && (m_split == '0) && m_done_res)

    // the split point lies inside its subchain
    `MCODP_ASSERT_IMP(a_split_range, aclk, aresetn,
        m_valid && (m_status == ST_OK) && (m_row != m_col) && (m_col != '0),
        (m_split >= m_row) && (m_split < m_col))

    // a stored dimension leaves the unit ready for the next beat
    `MCODP_ASSERT_NXT(a_load_ready, aclk, aresetn,
        s_valid && s_ready && !s_last,
        s_ready)

    `MCODP_ASSERT_NXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready,
        m_valid && $stable(m_row) && $stable(m_col) && $stable(m_cost) && $stable(m_split))

endmodule

bind matrix_chain_order_dp_unit mcodp_checker u_mcodp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_last     (s_last),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_row      (m_row),
    .m_col      (m_col),
    .m_cost     (m_cost),
    .m_split    (m_split),
    .m_status   (m_status),
    .m_done_res (m_done_res)
);

`default_nettype wire

// ===== dv/tb_matrix_chain_order_dp_unit.sv =====
// self-checking testbench for matrix_chain_order_dp_unit: drives dimension chains, predicts
// every (row, col) cost/split beat with its own dynamic program and checks them in order
// depends on mcodp_pkg and the unit's rtl
module tb_matrix_chain_order_dp_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mcodp_pkg::*;

    localparam int CAP         = MAX_MATRICES_DEF;
    localparam int DW          = DIM_WIDTH_DEF;
    localparam int RAND_ITEMS  = 500;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_WAIT  = 400;

    typedef struct packed {
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [COST_W-1:0]   cost;
        logic [IDX_W-1:0]    split;
        logic [STATUS_W-1:0] status;
        logic                done;
    } chain_beat_t;

    typedef enum int {DM_SMALL, DM_FULL, DM_EDGE, DM_FLAT} dim_mode_t;

    class chain_scoreboard;
        logic [DW-1:0]  dims [0:CAP];
        int unsigned    dim_cnt;
        bit             overflow;
        chain_beat_t    pending_q[$];
        int unsigned    chains;
        int unsigned    status_beats;
        int unsigned    checked;
        int unsigned    mismatches;

        function new();
            dim_cnt      = 0;
            overflow     = 0;
            chains       = 0;
            status_beats = 0;
            checked      = 0;
            mismatches   = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void add_beat(int r, int c, logic [COST_W-1:0] cost, int sp,
                               logic [STATUS_W-1:0] st, bit done);
            chain_beat_t b;
            b.row    = r[IDX_W-1:0];
            b.col    = c[IDX_W-1:0];
            b.cost   = cost;
            b.split  = sp[IDX_W-1:0];
            b.status = st;
            b.done   = done;
            pending_q.push_back(b);
        endfunction

        function logic [COST_W-1:0] sat_sum(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
            logic [COST_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[COST_W] ? '1 : s[COST_W-1:0];
        endfunction

        // store one dimension beat; on the final one, build every expected beat of the chain
        function void note_dimension(logic [DW-1:0] d, logic is_last);
            logic [COST_W-1:0] cost_t [1:CAP][1:CAP];
            logic [COST_W-1:0] best;
            logic [COST_W-1:0] q;
            logic [63:0]       prod;
            int                n;
            int                span;
            int                i;
            int                j;
            int                k;
            int                bk;
            if (dim_cnt < CAP + 1) begin
                dims[dim_cnt] = d;
                dim_cnt++;
            end else begin
                overflow = 1;
            end
            if (!is_last)
                return;
            chains++;
            if (overflow) begin
                add_beat(0, 0, '0, 0, ST_LONG, 1);
                status_beats++;
            end else if (dim_cnt < 2) begin
                add_beat(0, 0, '0, 0, ST_SHORT, 1);
                status_beats++;
            end else begin
                n = dim_cnt - 1;
                for (i = 1; i <= n; i++)
                    cost_t[i][i] = '0;
                if (n == 1) begin
                    add_beat(1, 1, '0, 0, ST_OK, 1);
                end else begin
                    for (span = 2; span <= n; span++) begin
                        for (i = 1; i + span - 1 <= n; i++) begin
                            j    = i + span - 1;
                            best = '1;
                            bk   = i;
                            for (k = i; k < j; k++) begin
                                prod = 64'(dims[i-1]) * 64'(dims[k]) * 64'(dims[j]);
                                q = sat_sum(sat_sum(cost_t[i][k], cost_t[k+1][j]),
                                            (prod[63:COST_W] != 0) ? '1 : prod[COST_W-1:0]);
                                // only a strictly cheaper split replaces the best, ties keep low k
                                if (k == i || q < best) begin
                                    best = q;
                                    bk   = k;
                                end
                            end
                            cost_t[i][j] = best;
                            add_beat(i, j, best, bk, ST_OK, span == n);
                        end
                    end
                end
            end
            dim_cnt  = 0;
            overflow = 0;
        endfunction

        function void check_result(chain_beat_t got);
            chain_beat_t exp_b;
            checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: row %0d col %0d cost %0d split %0d %s %0d done %0d",
                             got.row, got.col, got.cost, got.split, "status", got.status,
                             got.done);
                return;
            end
            exp_b = pending_q.pop_front();
            if (got.row !== exp_b.row || got.col !== exp_b.col || got.cost !== exp_b.cost ||
                got.split !== exp_b.split || got.status !== exp_b.status ||
                got.done !== exp_b.done) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp: row %0d col %0d cost %0d split %0d status %0d done %0d",
                             exp_b.row, exp_b.col, exp_b.cost, exp_b.split, exp_b.status,
                             exp_b.done);
                    $display("         got: row %0d col %0d cost %0d split %0d status %0d done %0d",
                             got.row, got.col, got.cost, got.split, got.status, got.done);
                end
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [DW-1:0]       s_dimension = '0;
    logic                s_last      = 1'b0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [IDX_W-1:0]    m_row;
    logic [IDX_W-1:0]    m_col;
    logic [COST_W-1:0]   m_cost;
    logic [IDX_W-1:0]    m_split;
    logic [STATUS_W-1:0] m_status;
    logic                m_done_res;

    chain_scoreboard sb = new();
    bit              idle_off   = 0;
    int unsigned     items_sent = 0;
    int unsigned     cycle_cnt  = 0;

    matrix_chain_order_dp_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_dimension(s_dimension),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_row      (m_row),
        .m_col      (m_col),
        .m_cost     (m_cost),
        .m_split    (m_split),
        .m_status   (m_status),
        .m_done_res (m_done_res)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random backpressure, check every accepted beat
    always @(negedge aclk) begin
        m_ready <= idle_off ? 1'b1 : ($urandom_range(99) >= 18);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(chain_beat_t'{m_row, m_col, m_cost, m_split, m_status,
                                          m_done_res});
    end

    task automatic send_dim(input logic [DW-1:0] d, input logic is_last);
        @(negedge aclk);
        while (!idle_off && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_dimension <= d;
        s_last      <= is_last;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_dimension(d, is_last);
        items_sent++;
    endtask

    task automatic send_list(input logic [DW-1:0] dl[$]);
        foreach (dl[idx])
            send_dim(dl[idx], idx == dl.size() - 1);
    endtask

    // drop valid first so the last beat is not taken again once the unit is ready
    task automatic wait_all_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [DW-1:0] pick_dim(dim_mode_t mode, logic [DW-1:0] flat_val);
        case (mode)
            DM_SMALL: return DW'($urandom_range(16, 1));
            DM_FULL:  return DW'($urandom_range(4095, 0));
            DM_EDGE: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return DW'(1);
                    2: return {1'b1, {(DW-1){1'b0}}};
                    default: return '1;
                endcase
            end
            default: return flat_val;
        endcase
    endfunction

    task automatic send_random_chain();
        int            pick;
        int            n_dims;
        dim_mode_t     mode;
        logic [DW-1:0] flat_val;
        pick = $urandom_range(99);
        if (pick < 6)
            n_dims = 1;
        else if (pick < 12)
            n_dims = $urandom_range(CAP + 4, CAP + 2);
        else if (pick < 30)
            n_dims = CAP + 1;
        else
            n_dims = $urandom_range(CAP + 1, 2);
        mode     = dim_mode_t'($urandom_range(3));
        flat_val = DW'($urandom_range(4095, 1));
        for (int idx = 0; idx < n_dims; idx++)
            send_dim(pick_dim(mode, flat_val), idx == n_dims - 1);
    endtask

    initial begin
        logic [DW-1:0] dl[$];

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // lone dimension: fewer than two
        dl = '{DW'(77)};
        send_list(dl);
        wait_all_results();
        // one matrix, with a zero dimension
        dl = '{DW'(0), DW'(4095)};
        send_list(dl);
        wait_all_results();
        dl = '{DW'(10), DW'(20), DW'(30), DW'(40), DW'(30)};
        send_list(dl);
        wait_all_results();
        // full chain at maximum dimension, every split ties
        dl = {};
        repeat (CAP + 1) dl.push_back('1);
        send_list(dl);
        wait_all_results();
        // one beat over capacity
        dl = {};
        for (int v = 1; v <= CAP + 2; v++) dl.push_back(DW'(v));
        send_list(dl);
        wait_all_results();

        while (items_sent < RAND_ITEMS) begin
            idle_off = (items_sent >= 200 && items_sent < 300);
            send_random_chain();
            if ($urandom_range(99) < 5)
                wait_all_results();
        end
        idle_off = 0;
        @(negedge aclk);
        s_valid <= 1'b0;

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d chains in %0d dimension beats; %0d result beats checked, %0d status",
                 sb.chains, items_sent, sb.checked, sb.status_beats);
        $display("mismatches: %0d, beats still expected: %0d", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
